// ----- rtl/pixel_depth_mean_variance_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the pixel depth mean/variance block
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef PIXEL_DEPTH_MEAN_VARIANCE_MACROS_SVH
`define PIXEL_DEPTH_MEAN_VARIANCE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDMV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdmv assertion failed");

// next-cycle implication, disabled during reset
`define PDMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdmv assertion failed");

`endif

// ----- rtl/pdmv_pkg.sv -----
// ---------------------------------------------------------------------------
// pdmv_pkg
// Shared widths, codes, entry layout and state type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdmv_pkg;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 19;
  localparam int SAMPLE_W = 11;
  localparam int LIMIT_W  = 12;
  localparam int MEAN_W   = 15;
  localparam int VAR_W    = 24;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 19;
  localparam int SQ_W     = 30;
  localparam int FRAC_W   = 4;

  localparam int PROD_W   = CNT_W + SQ_W;
  localparam int NN_W     = 2 * CNT_W;
  localparam int MDIV_W   = SUM_W + FRAC_W;
  localparam int VDIV_W   = PROD_W + FRAC_W;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCUM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [PADDR_W-3:0] REG_VALID_LIMIT = 1'b0;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic             dropped;
  } pdmv_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } pdmv_state_t;

endpackage

// ----- rtl/pdmv_req_if.sv -----
// ---------------------------------------------------------------------------
// pdmv_req_if
// Request channel: mode, pixel index and depth sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pdmv_req_if import pdmv_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [IDX_W-1:0]    pixel_index;
  logic [SAMPLE_W-1:0] depth_sample;

  modport source (output valid, mode, pixel_index, depth_sample, input ready);
  modport sink   (input valid, mode, pixel_index, depth_sample, output ready);
endinterface

// ----- rtl/pdmv_rsp_if.sv -----
// ---------------------------------------------------------------------------
// pdmv_rsp_if
// Result channel: pixel statistics.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pdmv_rsp_if import pdmv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_q4;
  logic [VAR_W-1:0]  variance_q4;
  logic [CNT_W-1:0]  sample_count;
  logic              no_samples;
  logic              saturated;

  modport source (output valid, mean_q4, variance_q4, sample_count, no_samples, saturated,
                  input ready);
  modport sink   (input valid, mean_q4, variance_q4, sample_count, no_samples, saturated,
                  output ready);
endinterface

// ----- rtl/pdmv_store.sv -----
// ---------------------------------------------------------------------------
// pdmv_store
// Per-pixel statistics memory, one port, registered read, zeroing sweep
// after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdmv_store import pdmv_pkg::*; #(
  parameter int PIXELS = 307200,
  parameter int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd,
  input  logic        wr,
  input  logic [AW-1:0] addr,
  input  pdmv_entry_t wdata,
  output pdmv_entry_t rdata,
  output logic        init_done
);

  localparam logic [AW-1:0] LAST = AW'(PIXELS - 1);

  pdmv_entry_t mem [PIXELS];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  pdmv_entry_t   mem_wd;

  assign mem_we   = !init_done || wr;
  assign mem_addr = init_done ? addr : clr_addr;
  assign mem_wd   = init_done ? wdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      init_done <= 1'b0;
    end else if (!init_done) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST) begin
        init_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (rd && init_done) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/pdmv_div.sv -----
// ---------------------------------------------------------------------------
// pdmv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdmv_div #(
  parameter int WN = 42,
  parameter int WD = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WN-1:0] dividend,
  input  logic [WD-1:0] divisor,
  output logic          busy,
  output logic [WN-1:0] quotient
);

  localparam int CW = $clog2(WN + 1);

  logic [WD-1:0] rem;
  logic [WD-1:0] div_r;
  logic [WN-1:0] quo;
  logic [CW-1:0] cnt;
  logic [WD:0]   trial;
  logic [WD:0]   diff;
  logic          ge;

  assign trial    = {rem, quo[WN-1]};
  assign diff     = trial - {1'b0, div_r};
  assign ge       = trial >= {1'b0, div_r};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WN);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WD-1:0] : trial[WD-1:0];
      quo <= {quo[WN-2:0], ge};
    end
  end

endmodule

// ----- rtl/pixel_depth_mean_variance.sv -----
// Sequence: clear writes a zeroed entry; accumulate reads the memory, then writes back;
// read fetches, forms the products, runs the dividers and loads the result register,
// skipping the dividers when the pixel holds no samples, then returns to idle.
// Throughput: one request at a time; reads are set by the bit-serial variance
// divider, one quotient bit per cycle, plus any wait on the result register.
// Reset: valid_limit returns to 2000; a zeroing sweep then runs over every entry
// of the statistics memory, and no request is taken until it ends.
// ---------------------------------------------------------------------------
// pixel_depth_mean_variance
// Per-pixel temporal count, sum and sum of squares of depth samples, with
// mean and population variance readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_depth_mean_variance_macros.svh"

module pixel_depth_mean_variance import pdmv_pkg::*; #(
  parameter int PIXELS     = 307200,
  parameter int MAX_FRAMES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  pdmv_req_if.sink           req,
  pdmv_rsp_if.source         rsp
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_FRAMES);

  // configuration
  logic [LIMIT_W-1:0] valid_limit;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_VALID_LIMIT);
  assign prdata  = reg_hit ? PDATA_W'(valid_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      valid_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // sequencer
  pdmv_state_t state, state_next;
  logic        init_done;
  logic        accept;
  logic        in_range;
  logic        mem_rd, mem_wr;
  logic [AW-1:0] mem_addr;
  pdmv_entry_t mem_wd, mem_rdata, acc_entry;
  logic        div_start, out_load, out_free;
  logic        mean_busy, var_busy;

  logic [MODE_W-1:0]   op_mode;
  logic [AW-1:0]       op_addr;
  logic [SAMPLE_W-1:0] op_sample;

  logic [PROD_W-1:0]   prod_a, prod_b, prod_diff;
  logic [NN_W-1:0]     prod_nn;
  logic [CNT_W-1:0]    cur_n;
  logic [SUM_W-1:0]    cur_sum;
  logic                cur_drop, zero_n;
  logic [MDIV_W-1:0]   mean_quo;
  logic [VDIV_W-1:0]   var_quo;
  logic [2*SAMPLE_W-1:0] d_sq;
  logic                d_ok;

  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;
  logic [CNT_W-1:0]  count_r;
  logic              empty_r, sat_r, out_valid;

  assign in_range = (32'(req.pixel_index) < 32'(PIXELS));
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_range && (req.mode == MODE_ACCUM || req.mode == MODE_READ)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (op_mode != MODE_READ) begin
          state_next = ST_IDLE;
        end else if (mem_rdata.cnt == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (!mean_busy && !var_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = op_addr;
    mem_wd    = acc_entry;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = init_done && !rst;
        mem_addr  = AW'(req.pixel_index);
        mem_wd    = '0;
        if (accept && in_range) begin
          mem_wr = (req.mode == MODE_CLEAR);
          mem_rd = (req.mode == MODE_ACCUM) || (req.mode == MODE_READ);
        end
      end
      ST_FETCH: mem_wr = (op_mode == MODE_ACCUM);
      ST_MUL:   div_start = 1'b1;
      ST_DIV:   ;
      ST_EMIT:  out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  pdmv_store #(.PIXELS(PIXELS), .AW(AW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (mem_rd),
    .wr       (mem_wr),
    .addr     (mem_addr),
    .wdata    (mem_wd),
    .rdata    (mem_rdata),
    .init_done(init_done)
  );

  // accumulate: modify the fetched entry
  assign d_sq = op_sample * op_sample;
  assign d_ok = ({1'b0, op_sample} < valid_limit);

  always_comb begin
    acc_entry = mem_rdata;
    if (d_ok) begin
      if (mem_rdata.cnt >= FULL) begin
        acc_entry.dropped = 1'b1;
      end else begin
        acc_entry.cnt = mem_rdata.cnt + CNT_W'(1);
        acc_entry.sum = mem_rdata.sum + SUM_W'(op_sample);
        acc_entry.sq  = mem_rdata.sq + SQ_W'(d_sq);
      end
    end
  end

  // read: products, then dividers
  assign prod_diff = (prod_a > prod_b) ? (prod_a - prod_b) : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode   <= req.mode;
      op_addr   <= AW'(req.pixel_index);
      op_sample <= req.depth_sample;
    end
    if (state == ST_FETCH) begin
      prod_a   <= PROD_W'(mem_rdata.cnt) * PROD_W'(mem_rdata.sq);
      prod_b   <= PROD_W'(mem_rdata.sum) * PROD_W'(mem_rdata.sum);
      prod_nn  <= mem_rdata.cnt * mem_rdata.cnt;
      cur_n    <= mem_rdata.cnt;
      cur_sum  <= mem_rdata.sum;
      cur_drop <= mem_rdata.dropped;
      zero_n   <= (mem_rdata.cnt == '0);
    end
  end

  pdmv_div #(.WN(MDIV_W), .WD(CNT_W)) u_mean_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({cur_sum, FRAC_W'(0)}),
    .divisor (cur_n),
    .busy    (mean_busy),
    .quotient(mean_quo)
  );

  pdmv_div #(.WN(VDIV_W), .WD(NN_W)) u_var_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({prod_diff, FRAC_W'(0)}),
    .divisor (prod_nn),
    .busy    (var_busy),
    .quotient(var_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count_r <= cur_n;
      empty_r <= zero_n;
      sat_r   <= cur_drop;
      if (zero_n) begin
        mean_r <= '0;
        var_r  <= '0;
      end else begin
        mean_r <= (|mean_quo[MDIV_W-1:MEAN_W]) ? '1 : mean_quo[MEAN_W-1:0];
        var_r  <= (|var_quo[VDIV_W-1:VAR_W]) ? '1 : var_quo[VAR_W-1:0];
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.mean_q4      = mean_r;
  assign rsp.variance_q4  = var_r;
  assign rsp.sample_count = count_r;
  assign rsp.no_samples   = empty_r;
  assign rsp.saturated    = sat_r;

  `PDMV_ASSERT_SAME(a_emit_after_div, clk, rst, state == ST_EMIT && !zero_n, !mean_busy && !var_busy)
  `PDMV_ASSERT_NEXT(a_read_fetch, clk, rst, accept && in_range && req.mode == MODE_READ, state == ST_FETCH)
  `PDMV_ASSERT_SAME(a_no_wr_in_div, clk, rst, var_busy || mean_busy, !mem_wr && !req.ready)
  `PDMV_ASSERT_SAME(a_out_from_emit, clk, rst, $rose(out_valid), $past(state) == ST_EMIT)

endmodule
